>>> rtl/step_gate_gain_generator_defines.svh
// assertion macros for the step gate gain generator
// used by the top level only, no other dependencies
`ifndef STEP_GATE_GAIN_GENERATOR_DEFINES_SVH
`define STEP_GATE_GAIN_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SGG_ASSERT_NOW(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SGG_ASSERT_NXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/sgg_pkg.sv
// shared types, constants and shape tables for the step gate gain generator
// no dependencies; tables are built by constant functions at elaboration
`default_nettype none

package sgg_pkg;

    localparam int MAX_STEPS    = 32;
    localparam int FRAC_BITS    = 16;
    localparam int TAB_DEPTH    = 256;
    localparam int CFG_ADDR_W   = 5;
    localparam logic [16:0] ONE       = 17'h10000;
    localparam logic [16:0] SWING_MAX = 17'd49152;
    localparam logic [16:0] EDGE_Q    = 17'd9830;
    localparam logic [24:0] S_ONE     = 25'h1000000;
    // ceil(2^44 / EDGE_Q): d * EDGE_RECIP >> 28 is floor(d * ONE / EDGE_Q) for d < EDGE_Q
    localparam logic [31:0] EDGE_RECIP = 32'd1789642528;

    typedef logic [16:0] t_tab [0:TAB_DEPTH];

    typedef enum logic [2:0] {
        REG_STEP_LENGTH,
        REG_SWING,
        REG_PHASE_OFFSET,
        REG_DEPTH,
        REG_SHAPE,
        REG_SMOOTH,
        REG_LONG_PATTERN
    } t_reg_idx;

    typedef enum logic [2:0] {
        SH_SQUARE,
        SH_SMOOTH,
        SH_RAMP_UP,
        SH_RAMP_DOWN,
        SH_TRIANGLE,
        SH_SINE,
        SH_CURVED
    } t_shape;

    typedef enum logic [4:0] {
        ST_IDLE, ST_OFF, ST_SUM, ST_DIV, ST_FQ, ST_CMP, ST_SQ, ST_FDIV,
        ST_SHAPE, ST_EDIV, ST_LK1, ST_LK2, ST_LK3, ST_SQV, ST_SQG,
        ST_LVL, ST_TGT, ST_SM1, ST_SM2, ST_SM3, ST_OUT
    } t_state;

    typedef struct packed {
        logic [23:0] step_length;
        logic [15:0] swing;
        logic [16:0] phase_offset;
        logic [16:0] depth;
        logic [2:0]  shape;
        logic [15:0] smooth;
        logic        long_pattern;
    } t_cfg;

    typedef struct packed {
        logic        load;
        logic        step;
        logic [40:0] rem0;
        logic [32:0] dvd0;
        logic [40:0] dvs;
    } t_div_ctl;

    typedef struct packed {
        logic [4:0]  step;
        logic [16:0] target;
        logic [16:0] gain;
    } t_res;

    localparam logic [63:0] Q30_ONE = 64'h40000000;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic signed [63:0] sum;
        logic [63:0] term;
        sum  = signed'(x);
        term = x;
        for (int k = 1; k <= 8; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum = sum - signed'(term);
            else sum = sum + signed'(term);
        end
        if (sum < 0) return 64'd0;
        if (unsigned'(sum) > Q30_ONE) return Q30_ONE;
        return unsigned'(sum);
    endfunction

    function automatic logic [63:0] pow_q30(input logic [63:0] y, input int n);
        logic [63:0] r;
        r = Q30_ONE;
        for (int i = 0; i < n; i++) r = (r * y) >> 30;
        return r;
    endfunction

    function automatic logic [16:0] q30_to_gain(input logic [63:0] v);
        logic [63:0] g;
        g = (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        return (g > 64'(ONE)) ? ONE : g[16:0];
    endfunction

    // curved = sin^(7/20), found by a bit search on the 20th root
    function automatic t_tab build_tab(input logic curved);
        t_tab tab;
        logic [63:0] j, s, c, y, t;
        for (int i = 0; i <= TAB_DEPTH; i++) begin
            j = (i * 2 > TAB_DEPTH) ? 64'(TAB_DEPTH - i) : 64'(i);
            s = sin_q30((PI_Q30 * j) / TAB_DEPTH);
            c = 64'd0;
            if (curved) begin
                if (s >= Q30_ONE) begin
                    c = Q30_ONE;
                end else if (s > 0) begin
                    y = 64'd0;
                    for (int b = 29; b >= 0; b--) begin
                        t = y | (64'd1 << b);
                        if (pow_q30(t, 20) <= s) y = t;
                    end
                    c = pow_q30(y, 7);
                end
                tab[i] = q30_to_gain(c);
            end else begin
                tab[i] = q30_to_gain(s);
            end
        end
        return tab;
    endfunction

    localparam t_tab SIN_TAB   = build_tab(1'b0);
    localparam t_tab CURVE_TAB = build_tab(1'b1);

endpackage

`default_nettype wire

>>> rtl/sgg_alu.sv
// shared arithmetic unit: one registered multiplier and a restoring
// divider that produces one quotient bit per step; uses sgg_pkg
`default_nettype none

module sgg_alu (
    input  wire logic              i_clk,
    input  wire logic [31:0]       i_mul_a,
    input  wire logic [31:0]       i_mul_b,
    input  wire sgg_pkg::t_div_ctl i_div,
    output logic [63:0]            o_prod,
    output logic [40:0]            o_rem,
    output logic [32:0]            o_quo
);
    import sgg_pkg::*;

    logic [63:0] r_prod;
    logic [40:0] r_rem, n_rem;
    logic [32:0] r_dvd, n_dvd;
    logic [32:0] r_quo, n_quo;
    logic [40:0] r_dvs, n_dvs;
    logic [41:0] w_shift;
    logic [41:0] w_diff;

    assign w_shift = {r_rem, r_dvd[32]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_comb begin
        n_rem = r_rem;
        n_dvd = r_dvd;
        n_quo = r_quo;
        n_dvs = r_dvs;
        if (i_div.load) begin
            n_rem = i_div.rem0;
            n_dvd = i_div.dvd0;
            n_quo = '0;
            n_dvs = i_div.dvs;
        end else if (i_div.step) begin
            n_dvd = {r_dvd[31:0], 1'b0};
            if (w_shift >= {1'b0, r_dvs}) begin
                n_rem = w_diff[40:0];
                n_quo = {r_quo[31:0], 1'b1};
            end else begin
                n_rem = w_shift[40:0];
                n_quo = {r_quo[31:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_mul_a * i_mul_b;
        r_rem  <= n_rem;
        r_dvd  <= n_dvd;
        r_quo  <= n_quo;
        r_dvs  <= n_dvs;
    end

    assign o_prod = r_prod;
    assign o_rem  = r_rem;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

>>> rtl/sgg_cfg.sv
// configuration register file behind the apb-style port
// uses sgg_pkg for register indexes and the t_cfg bundle
`default_nettype none

module sgg_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sgg_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output sgg_pkg::t_cfg                      o_cfg
);
    import sgg_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_length  <= 24'd5512;
            r_cfg.swing        <= '0;
            r_cfg.phase_offset <= '0;
            r_cfg.depth        <= ONE;
            r_cfg.shape        <= '0;
            r_cfg.smooth       <= '0;
            r_cfg.long_pattern <= 1'b0;
        end else if (w_wr) begin
            case (w_idx)
                REG_STEP_LENGTH:  r_cfg.step_length  <= pwdata[23:0];
                REG_SWING:        r_cfg.swing        <= pwdata[15:0];
                REG_PHASE_OFFSET: r_cfg.phase_offset <= pwdata[16:0];
                REG_DEPTH:        r_cfg.depth        <= pwdata[16:0];
                REG_SHAPE:        r_cfg.shape        <= pwdata[2:0];
                REG_SMOOTH:       r_cfg.smooth       <= pwdata[15:0];
                REG_LONG_PATTERN: r_cfg.long_pattern <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_STEP_LENGTH:  prdata = {8'd0, r_cfg.step_length};
            REG_SWING:        prdata = {16'd0, r_cfg.swing};
            REG_PHASE_OFFSET: prdata = {15'd0, r_cfg.phase_offset};
            REG_DEPTH:        prdata = {15'd0, r_cfg.depth};
            REG_SHAPE:        prdata = {29'd0, r_cfg.shape};
            REG_SMOOTH:       prdata = {16'd0, r_cfg.smooth};
            REG_LONG_PATTERN: prdata = {31'd0, r_cfg.long_pattern};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> rtl/sgg_seq.sv
// sequencer: walks one sample through the shared multiplier and divider,
// holds pattern levels and the smoothing state; uses sgg_pkg
`default_nettype none

module sgg_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sgg_pkg::t_cfg     i_cfg,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_mode,
    input  wire logic [31:0]       i_pos,
    input  wire logic [4:0]        i_step_index,
    input  wire logic [16:0]       i_step_level,
    output logic                   o_res_valid,
    input  wire logic              i_res_taken,
    output sgg_pkg::t_res          o_res,
    output logic [31:0]            o_mul_a,
    output logic [31:0]            o_mul_b,
    output sgg_pkg::t_div_ctl      o_div,
    input  wire logic [63:0]       i_prod,
    input  wire logic [40:0]       i_rem,
    input  wire logic [32:0]       i_quo
);
    import sgg_pkg::*;

    t_state r_state, n_state;
    logic [16:0] r_pat [0:MAX_STEPS-1];
    logic [24:0] r_s, n_s;
    logic [31:0] r_pos;
    logic [5:0]  r_cnt, n_cnt;
    logic [4:0]  r_idx, n_idx;
    logic [40:0] r_num, n_num;
    logic [16:0] r_lk, n_lk;
    logic        r_curve, n_curve;
    logic        r_edge, n_edge;
    logic [33:0] r_acc, n_acc;
    logic [16:0] r_g, n_g;
    logic [16:0] r_tgt, n_tgt;
    logic        r_ge, n_ge;

    logic [23:0] w_len;
    logic [28:0] w_total;
    logic [16:0] w_ph, w_sw, w_dep;
    logic [32:0] w_sum;
    logic [40:0] w_wq;
    logic [16:0] w_x;
    logic [8:0]  w_i0, w_i1;
    logic [16:0] w_t0, w_t1;
    logic [15:0] w_f;
    logic [34:0] w_lsum;
    logic [17:0] w_tgt;
    logic [24:0] w_t, w_adj;
    logic [25:0] w_snew;
    logic [3:0]  w_pair;

    assign w_len   = (i_cfg.step_length == '0) ? 24'd1 : i_cfg.step_length;
    assign w_total = i_cfg.long_pattern ? {w_len, 5'd0} : {1'b0, w_len, 4'd0};
    assign w_ph    = (i_cfg.phase_offset > ONE) ? ONE : i_cfg.phase_offset;
    assign w_sw    = ({1'b0, i_cfg.swing} > SWING_MAX) ? SWING_MAX : {1'b0, i_cfg.swing};
    assign w_dep   = (i_cfg.depth > ONE) ? ONE : i_cfg.depth;
    assign w_sum   = {1'b0, r_pos} + 33'(i_prod[45:16]);
    assign w_wq    = {i_rem[24:0], 16'd0};
    assign w_x     = {1'b0, i_quo[15:0]};
    assign w_pair  = i_cfg.long_pattern ? i_quo[3:0] : {1'b0, i_quo[2:0]};

    // table interpolation; the top entry reads itself twice
    assign w_i0   = r_lk[16:8];
    assign w_i1   = (w_i0 == 9'(TAB_DEPTH)) ? w_i0 : w_i0 + 9'd1;
    assign w_t0   = r_curve ? CURVE_TAB[w_i0] : SIN_TAB[w_i0];
    assign w_t1   = r_curve ? CURVE_TAB[w_i1] : SIN_TAB[w_i1];
    assign w_f    = {r_lk[7:0], 8'd0};
    assign w_lsum = {1'b0, r_acc} + {1'b0, i_prod[33:0]};

    assign w_tgt  = {1'b0, ONE} - {1'b0, w_dep} + {1'b0, i_prod[32:16]};
    assign w_t    = {r_tgt, 8'd0};
    assign w_adj  = i_prod[40:16];
    assign w_snew = r_ge ? ({1'b0, w_t} + {1'b0, w_adj}) : ({1'b0, w_t} - {1'b0, w_adj});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_s     <= S_ONE;
            for (int k = 0; k < MAX_STEPS; k++) r_pat[k] <= '0;
        end else begin
            r_state <= n_state;
            r_s     <= n_s;
            if (r_state == ST_IDLE && i_valid && i_mode) begin
                r_pat[i_step_index] <= (i_step_level > ONE) ? ONE : i_step_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) r_pos <= i_pos;
        r_cnt   <= n_cnt;
        r_idx   <= n_idx;
        r_num   <= n_num;
        r_lk    <= n_lk;
        r_curve <= n_curve;
        r_edge  <= n_edge;
        r_acc   <= n_acc;
        r_g     <= n_g;
        r_tgt   <= n_tgt;
        r_ge    <= n_ge;
    end

    always_comb begin
        n_state = r_state;
        n_s     = r_s;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_num   = r_num;
        n_lk    = r_lk;
        n_curve = r_curve;
        n_edge  = r_edge;
        n_acc   = r_acc;
        n_g     = r_g;
        n_tgt   = r_tgt;
        n_ge    = r_ge;
        o_mul_a = '0;
        o_mul_b = '0;
        o_div   = '0;
        o_ready = 1'b0;
        o_res_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && !i_mode) n_state = ST_OFF;
            end
            ST_OFF: begin
                o_mul_a = 32'(w_ph);
                o_mul_b = 32'(w_total);
                n_state = ST_SUM;
            end
            ST_SUM: begin
                // quotient by two steps gives the pair, remainder the offset in it
                o_div.load = 1'b1;
                o_div.dvd0 = w_sum;
                o_div.dvs  = 41'({w_len, 1'b0});
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_div.step = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd32) n_state = ST_FQ;
            end
            ST_FQ: begin
                o_mul_a = 32'(w_len);
                o_mul_b = 32'({1'b0, ONE} + {1'b0, w_sw});
                n_state = ST_CMP;
            end
            ST_CMP: begin
                n_cnt = '0;
                if (w_wq < i_prod[40:0]) begin
                    n_idx = {w_pair, 1'b0};
                    o_div.load = 1'b1;
                    o_div.rem0 = w_wq;
                    o_div.dvs  = i_prod[40:0];
                    n_state = ST_FDIV;
                end else begin
                    n_idx = {w_pair, 1'b1};
                    n_num = w_wq - i_prod[40:0];
                    o_mul_a = 32'(w_len);
                    o_mul_b = 32'(ONE - w_sw);
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                o_div.load = 1'b1;
                o_div.rem0 = r_num;
                o_div.dvs  = i_prod[40:0];
                n_state = ST_FDIV;
            end
            ST_FDIV: begin
                o_div.step = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(FRAC_BITS - 1)) n_state = ST_SHAPE;
            end
            ST_SHAPE: begin
                n_edge  = 1'b0;
                n_curve = 1'b0;
                n_lk    = w_x;
                n_cnt   = '0;
                n_g     = ONE;
                n_state = ST_LVL;
                case (t_shape'(i_cfg.shape))
                    SH_SMOOTH: begin
                        if (w_x < EDGE_Q) begin
                            o_mul_a = 32'(w_x);
                            o_mul_b = EDGE_RECIP;
                            n_state = ST_EDIV;
                        end else if (w_x > ONE - EDGE_Q) begin
                            o_mul_a = 32'(ONE - w_x);
                            o_mul_b = EDGE_RECIP;
                            n_state = ST_EDIV;
                        end
                    end
                    SH_RAMP_UP:   n_g = w_x;
                    SH_RAMP_DOWN: n_g = ONE - w_x;
                    SH_TRIANGLE: begin
                        if ({w_x, 1'b0} <= {1'b0, ONE}) n_g = {w_x[15:0], 1'b0};
                        else n_g = 17'({ONE - w_x, 1'b0});
                    end
                    SH_SINE:   n_state = ST_LK1;
                    SH_CURVED: begin
                        n_curve = 1'b1;
                        n_state = ST_LK1;
                    end
                    default: ;
                endcase
            end
            ST_EDIV: begin
                // edge phase over the edge width, taken halved straight from the product
                n_edge  = 1'b1;
                n_lk    = 17'(i_prod[43:29]);
                n_state = ST_LK1;
            end
            ST_LK1: begin
                o_mul_a = 32'(w_t0);
                o_mul_b = 32'(ONE - 17'(w_f));
                n_state = ST_LK2;
            end
            ST_LK2: begin
                n_acc   = i_prod[33:0];
                o_mul_a = 32'(w_t1);
                o_mul_b = 32'(w_f);
                n_state = ST_LK3;
            end
            ST_LK3: begin
                n_g     = w_lsum[32:16];
                n_state = r_edge ? ST_SQV : ST_LVL;
            end
            ST_SQV: begin
                o_mul_a = 32'(r_g);
                o_mul_b = 32'(r_g);
                n_state = ST_SQG;
            end
            ST_SQG: begin
                n_g     = i_prod[32:16];
                n_state = ST_LVL;
            end
            ST_LVL: begin
                o_mul_a = 32'(r_pat[r_idx]);
                o_mul_b = 32'(r_g);
                n_state = ST_TGT;
            end
            ST_TGT: begin
                o_mul_a = 32'(w_dep);
                o_mul_b = 32'(i_prod[32:16]);
                n_state = ST_SM1;
            end
            ST_SM1: begin
                n_tgt   = (w_tgt > {1'b0, ONE}) ? ONE : w_tgt[16:0];
                n_state = ST_SM2;
            end
            ST_SM2: begin
                n_ge    = (r_s >= w_t);
                o_mul_a = 32'(i_cfg.smooth);
                o_mul_b = (r_s >= w_t) ? 32'(r_s - w_t) : 32'(w_t - r_s);
                n_state = ST_SM3;
            end
            ST_SM3: begin
                n_s     = (w_snew > {1'b0, S_ONE}) ? S_ONE : w_snew[24:0];
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_res_valid = 1'b1;
                if (i_res_taken) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_res.gain   = r_s[24:8];
    assign o_res.target = r_tgt;
    assign o_res.step   = r_idx;

endmodule

`default_nettype wire

>>> rtl/step_gate_gain_generator.sv
// top level of the step gate gain generator: config port, sequencer,
// shared arithmetic unit and the result register; uses sgg_pkg
//
// channel | direction | meaning
// s_axis  | in        | tuser = mode; tdata = sample_position, step_index, step_level
// m_axis  | out       | tdata = gain, target_gain, current_step
// apb     | in        | registers at byte address 4 * index
//
// a level write (mode 1) is taken in idle and leaves the sequencer ready; a sample
// holds ready low until its result is taken: 33 pair-division and 16 phase-division
// steps on the shared divider, the ST_SQ state for the second step of a pair, the LK1
// to LK3 table lookup states and the reciprocal and squaring of a smooth square edge
// reset is synchronous; pattern levels clear to zero, smoothing to unity gain
// a finished result waits in the output register while the next item is taken
`default_nettype none
`include "step_gate_gain_generator_defines.svh"

module step_gate_gain_generator (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] sample_position, [36:32] step_index, [53:37] step_level
    input  wire logic [55:0]                    s_axis_tdata,
    // [0] mode
    input  wire logic                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [16:0] gain, [33:17] target_gain, [38:34] current_step
    output logic [39:0]                         m_axis_tdata,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sgg_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import sgg_pkg::*;

    t_cfg        w_cfg;
    t_res        w_res;
    t_div_ctl    w_div;
    logic        w_res_valid, w_take, w_ready;
    logic [31:0] w_mul_a, w_mul_b;
    logic [63:0] w_prod;
    logic [40:0] w_rem;
    logic [32:0] w_quo;
    logic        r_mvalid;
    t_res        r_mres;

    sgg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sgg_alu u_alu (
        .i_clk   (i_clk),
        .i_mul_a (w_mul_a),
        .i_mul_b (w_mul_b),
        .i_div   (w_div),
        .o_prod  (w_prod),
        .o_rem   (w_rem),
        .o_quo   (w_quo)
    );

    sgg_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_valid      (s_axis_tvalid),
        .o_ready      (w_ready),
        .i_mode       (s_axis_tuser),
        .i_pos        (s_axis_tdata[31:0]),
        .i_step_index (s_axis_tdata[36:32]),
        .i_step_level (s_axis_tdata[53:37]),
        .o_res_valid  (w_res_valid),
        .i_res_taken  (w_take),
        .o_res        (w_res),
        .o_mul_a      (w_mul_a),
        .o_mul_b      (w_mul_b),
        .o_div        (w_div),
        .i_prod       (w_prod),
        .i_rem        (w_rem),
        .i_quo        (w_quo)
    );

    assign s_axis_tready = w_ready;
    assign w_take = w_res_valid && (!r_mvalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (w_take) begin
            r_mvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) r_mres <= w_res;
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = {1'b0, r_mres.step, r_mres.target, r_mres.gain};

    `SGG_ASSERT_NOW(a_gain_range, i_clk, i_rst_n, m_axis_tvalid, (r_mres.gain <= ONE) && (r_mres.target <= ONE), "gain out of range")
    `SGG_ASSERT_NXT(a_write_no_result, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser && !m_axis_tvalid, !m_axis_tvalid, "level write produced a result")
    `SGG_ASSERT_NXT(a_busy_after_sample, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && !s_axis_tuser, !s_axis_tready, "sample accepted while busy")

endmodule

`default_nettype wire
